// ===== rtl/mbd_pkg.sv =====
// Shared types and constants for the multi-button debouncer.
// Used by mbd_button_lane and multi_button_debouncer_top; depends on nothing.
package mbd_pkg;

    // Storage sizing.
    localparam int MAX_BUTTONS = 8;
    localparam int TIME_BITS   = 16;

    // Field widths fixed by the stream and configuration formats.
    localparam int PIN_BITS   = 8;
    localparam int IDX_BITS   = 3;
    localparam int CNT_BITS   = 4;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int NUM_LANES  = (MAX_BUTTONS < PIN_BITS) ? MAX_BUTTONS : PIN_BITS;
    localparam int CMP_BITS   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 24;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Input item kinds carried in s_tuser.
    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_CONSUME = 1'b1
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STARTUP_MS   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CNT_BITS-1:0] BUTTON_COUNT_RST = 4'd4;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_BITS-1:0] STARTUP_RST      = 16'd1000;

    // Per-lane control from the top level.
    typedef struct packed {
        logic tick;      // a tick transfer is being taken this cycle
        logic startup;   // uptime is still inside the startup window
        logic active;    // this button is in use
        logic clear;     // a consume transfer clears this button's latch
    } lane_ctrl_t;

    // Saturating increment of a time counter.
    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS-1:0] r;
        r = (v == TIME_MAX) ? TIME_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/mbd_button_lane.sv =====
// State and update logic for one debounced button.
// Depends on mbd_pkg for the lane control struct and time helpers.
module mbd_button_lane
    import mbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           ctrl,
    input  logic                 level,        // raw pin level, 0 means pressed
    input  logic [CFG_BITS-1:0]  debounce_ms,
    output logic                 latch,        // press latch before this cycle
    output logic                 stable_next,  // debounced level after this cycle
    output logic                 latch_next    // press latch after this cycle
);

    logic [TIME_BITS-1:0] age_reg;
    logic [TIME_BITS-1:0] age_next;
    logic                 reading_reg;
    logic                 reading_next;
    logic                 stable_reg;
    logic                 latch_reg;
    logic                 changed;
    logic [TIME_BITS-1:0] age_step;
    logic                 settled;

    // A change restarts the age; otherwise it grows and saturates.
    assign changed  = (level != reading_reg);
    assign age_step = changed ? '0 : sat_inc(age_reg);
    assign settled  = (CMP_BITS'(age_step) >= CMP_BITS'(debounce_ms));

    // Next state for a tick, a consume or an idle cycle.
    always_comb
    begin
        age_next     = age_reg;
        reading_next = reading_reg;
        stable_next  = stable_reg;
        latch_next   = latch_reg;
        if (ctrl.tick && ctrl.active)
        begin
            if (ctrl.startup)
            begin
                age_next     = '0;
                reading_next = level;
                stable_next  = level;
                latch_next   = 1'b0;
            end
            else
            begin
                age_next     = age_step;
                reading_next = level;
                if (settled)
                begin
                    stable_next = level;
                    if (!level && stable_reg)
                    begin
                        latch_next = 1'b1;
                    end
                end
            end
        end
        else if (ctrl.clear)
        begin
            latch_next = 1'b0;
        end
    end

    assign latch = latch_reg;

    // Lane registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg     <= '0;
            reading_reg <= 1'b1;
            stable_reg  <= 1'b1;
            latch_reg   <= 1'b0;
        end
        else
        begin
            age_reg     <= age_next;
            reading_reg <= reading_next;
            stable_reg  <= stable_next;
            latch_reg   <= latch_next;
        end
    end

endmodule

// ===== rtl/multi_button_debouncer_top.sv =====
// Top level of the multi-button debouncer: stream ports, configuration
// registers, shared uptime counter and result register. Uses mbd_pkg and mbd_button_lane.
//
//  Channel | Signals                                  | Direction | Content
//  s       | s_tvalid s_tready s_tdata s_tuser        | in        | tick or consume item
//  m       | m_tvalid m_tready m_tdata                | out       | one result per item
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in        | register write
//
// Each item updates the button state on the transfer edge, and its result is in the
// output register on the next cycle, so one item per cycle is sustained while m_tready
// is high. The output register is the only stage, and s_tready is low only while a
// result waits and m_tready is low. Reset is asynchronous and active low; it restores
// the register defaults and clears all button state. cfg_ready is always high.
module multi_button_debouncer_top
    import mbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [7:0] pin_levels, [10:8] button_index
    input  logic                     s_tuser,   // [0] cmd
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]  m_tdata,   // [0] press_seen, [1] raw_pressed,
                                                // [9:2] stable_pressed,
                                                // [17:10] pending_presses
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data
);

    logic [CNT_BITS-1:0]  button_count_reg;
    logic [CFG_BITS-1:0]  debounce_reg;
    logic [CFG_BITS-1:0]  startup_reg;
    logic [TIME_BITS-1:0] uptime_reg;
    logic [PIN_BITS-1:0]  pin_sample_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_BITS-1:0] m_data_reg;
    logic [M_TDATA_BITS-1:0] m_data_next;

    logic                 take;
    cmd_t                 cmd;
    logic                 is_tick;
    logic                 is_consume;
    logic [PIN_BITS-1:0]  pins;
    logic [IDX_BITS-1:0]  idx;
    logic                 idx_valid;
    logic                 startup;
    logic [PIN_BITS-1:0]  latch_cur;
    logic [PIN_BITS-1:0]  stable_nx;
    logic [PIN_BITS-1:0]  latch_nx;
    logic                 seen;
    logic                 raw;

    // Handshakes: a new item is taken whenever the result register is free or draining.
    assign s_tready  = !m_valid_reg || m_tready;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Unpack the input item.
    assign cmd        = cmd_t'(s_tuser);
    assign pins       = s_tdata[PIN_BITS-1:0];
    assign idx        = s_tdata[PIN_BITS+IDX_BITS-1:PIN_BITS];
    assign is_tick    = take && (cmd == CMD_TICK);
    assign is_consume = take && (cmd == CMD_CONSUME);
    assign idx_valid  = ({1'b0, idx} < button_count_reg) && (int'(idx) < NUM_LANES);
    assign startup    = (CMP_BITS'(uptime_reg) < CMP_BITS'(startup_reg));

    // One lane per button; pin bits with no lane keep their reset levels.
    for (genvar i = 0; i < PIN_BITS; i++)
    begin : g_lane
        if (i < NUM_LANES)
        begin : g_used
            lane_ctrl_t ctrl;
            assign ctrl.tick    = is_tick;
            assign ctrl.startup = startup;
            assign ctrl.active  = (button_count_reg > CNT_BITS'(i));
            assign ctrl.clear   = is_consume && idx_valid && (idx == IDX_BITS'(i));

            mbd_button_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .level       (pins[i]),
                .debounce_ms (debounce_reg),
                .latch       (latch_cur[i]),
                .stable_next (stable_nx[i]),
                .latch_next  (latch_nx[i])
            );
        end
        else
        begin : g_unused
            assign latch_cur[i] = 1'b0;
            assign stable_nx[i] = 1'b1;
            assign latch_nx[i]  = 1'b0;
        end
    end

    // Consume results for the selected button.
    assign seen = idx_valid && latch_cur[idx];
    assign raw  = idx_valid && !pin_sample_reg[idx];

    // Result word.
    always_comb
    begin
        m_data_next = '0;
        m_data_next[0]     = is_consume && seen;
        m_data_next[1]     = is_consume && raw;
        m_data_next[9:2]   = ~stable_nx;
        m_data_next[17:10] = latch_nx;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= BUTTON_COUNT_RST;
            debounce_reg     <= DEBOUNCE_RST;
            startup_reg      <= STARTUP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BUTTON_COUNT: button_count_reg <= cfg_data[CNT_BITS-1:0];
                REG_DEBOUNCE_MS:  debounce_reg     <= cfg_data;
                REG_STARTUP_MS:   startup_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Uptime and last pin sample, updated by ticks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uptime_reg     <= '0;
            pin_sample_reg <= '1;
        end
        else if (is_tick)
        begin
            uptime_reg     <= sat_inc(uptime_reg);
            pin_sample_reg <= pins;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for multi_button_debouncer_top: directed and random tick and
// consume transfers, with a scoreboard class that predicts every result word.
// Depends on mbd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
    import mbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    // Result word as it leaves m_tdata, lowest field last.
    typedef struct packed {
        logic [M_TDATA_BITS-19:0] pad;
        logic [7:0]               pending;
        logic [7:0]               stable;
        logic                     raw;
        logic                     seen;
    } result_t;

    // Predicts each result from its own copy of the debouncer state.
    class debounce_scoreboard;
        logic [CNT_BITS-1:0]  cfg_count;
        logic [CFG_BITS-1:0]  cfg_debounce;
        logic [CFG_BITS-1:0]  cfg_startup;
        logic [TIME_BITS-1:0] uptime;
        logic [7:0]           reading;
        logic [7:0]           stable;
        logic [7:0]           latch;
        logic [7:0]           pin_sample;
        logic [TIME_BITS-1:0] age [MAX_BUTTONS];
        result_t              expected_q [$];
        int unsigned          errors;
        int unsigned          results_seen;
        int unsigned          ticks;
        int unsigned          consumes;
        int unsigned          writes;
        int unsigned          presses_returned;

        function new();
            cfg_count    = BUTTON_COUNT_RST;
            cfg_debounce = DEBOUNCE_RST;
            cfg_startup  = STARTUP_RST;
            uptime       = '0;
            reading      = 8'hFF;
            stable       = 8'hFF;
            latch        = 8'h00;
            pin_sample   = 8'hFF;
            foreach (age[i]) age[i] = '0;
            errors = 0;
            results_seen = 0;
            ticks = 0;
            consumes = 0;
            writes = 0;
            presses_returned = 0;
        endfunction

        function logic [TIME_BITS-1:0] bump(logic [TIME_BITS-1:0] v);
            return (v == {TIME_BITS{1'b1}}) ? v : v + 1'b1;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_BUTTON_COUNT: cfg_count    = data[CNT_BITS-1:0];
                REG_DEBOUNCE_MS:  cfg_debounce = data;
                REG_STARTUP_MS:   cfg_startup  = data;
                default: ;
            endcase
            writes++;
        endfunction

        // Applies one accepted input transfer and queues the result it causes.
        function void note_input(cmd_t cmd, logic [7:0] pins, logic [2:0] sel);
            result_t     r;
            int unsigned n;
            logic        in_window;
            logic        lvl;
            r = '0;
            n = (cfg_count > MAX_BUTTONS) ? MAX_BUTTONS : cfg_count;
            if (n > PIN_BITS) n = PIN_BITS;
            if (cmd == CMD_TICK) begin
                in_window  = (uptime < cfg_startup);
                pin_sample = pins;
                for (int i = 0; i < n; i++) begin
                    lvl = pins[i];
                    if (in_window) begin
                        // Startup: readings go straight through, nothing latches.
                        reading[i] = lvl;
                        stable[i]  = lvl;
                        age[i]     = '0;
                        latch[i]   = 1'b0;
                    end
                    else begin
                        if (lvl != reading[i]) begin
                            reading[i] = lvl;
                            age[i]     = '0;
                        end
                        else begin
                            age[i] = bump(age[i]);
                        end
                        if (age[i] >= cfg_debounce) begin
                            if (!lvl && stable[i]) latch[i] = 1'b1;
                            stable[i] = lvl;
                        end
                    end
                end
                uptime = bump(uptime);
                ticks++;
            end
            else begin
                consumes++;
                if (sel < n) begin
                    r.seen     = latch[sel];
                    latch[sel] = 1'b0;
                    r.raw      = ~pin_sample[sel];
                    if (r.seen) presses_returned++;
                end
            end
            r.stable  = ~stable;
            r.pending = latch;
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        endtask

        // Compares one result transfer with the oldest prediction.
        task check_result(logic [M_TDATA_BITS-1:0] word);
            result_t got;
            result_t want;
            got = word;
            if (expected_q.size() == 0) begin
                report("unexpected result", 32'(word), 32'd0);
            end
            else begin
                want = expected_q.pop_front();
                if (got.seen !== want.seen)
                    report("press_seen", 32'(got.seen), 32'(want.seen));
                if (got.raw !== want.raw)
                    report("raw_pressed", 32'(got.raw), 32'(want.raw));
                if (got.stable !== want.stable)
                    report("stable_pressed", 32'(got.stable), 32'(want.stable));
                if (got.pending !== want.pending)
                    report("pending_presses", 32'(got.pending), 32'(want.pending));
                if (got.pad !== want.pad)
                    report("padding", 32'(got.pad), 32'(want.pad));
            end
            results_seen++;
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    debounce_scoreboard sb;
    int unsigned        cycle_count = 0;
    int unsigned        hold_cnt = 0;
    logic               rx_quiet = 1'b0;
    logic               tx_quiet = 1'b0;
    logic [7:0]         held = 8'hFF;
    logic [2:0]         bounce_bit = '0;
    int unsigned        bounce_left = 0;

    multi_button_debouncer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL multi_button_debouncer_top");
            $finish;
        end
    end

    // Receiver pacing: runs of ready and stall of random length.
    always @(posedge clk)
    begin : rx_pace
        int unsigned r;
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (rx_quiet) begin
            m_tready <= 1'b1;
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_tready <= 1'b1;
                hold_cnt <= $urandom_range(0, 4);
            end
            else if (r < 93) begin
                m_tready <= 1'b0;
                hold_cnt <= $urandom_range(0, 3);
            end
            else begin
                m_tready <= 1'b0;
                hold_cnt <= $urandom_range(8, 40);
            end
        end
    end

    // Watches every transfer on the three channels.
    always @(posedge clk)
    begin
        if (rst_n && sb != null) begin
            if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_input(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[10:8]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one item and waits for its transfer; a gap may follow.
    task automatic push_item(cmd_t cmd, logic [7:0] pins, logic [2:0] sel);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_BITS-11){1'b0}}, sel, pins};
        do @(posedge clk); while (!s_tready);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Button count with random bits above the register width.
    task automatic set_count(logic [CNT_BITS-1:0] cnt);
        logic [CFG_BITS-1:0] value;
        value = CFG_BITS'($urandom);
        value[CNT_BITS-1:0] = cnt;
        set_reg(REG_BUTTON_COUNT, value);
    endtask

    // Mostly held levels that may bounce after an edge, some consumes, some noise.
    task automatic run_random(int unsigned count);
        int unsigned r;
        logic [7:0]  pins;
        logic [2:0]  sel;
        for (int unsigned k = 0; k < count; k++) begin
            r    = $urandom_range(0, 99);
            pins = 8'($urandom);
            sel  = 3'($urandom_range(0, 7));
            if (r < 25) begin
                push_item(CMD_CONSUME, pins, sel);
            end
            else if (r < 30) begin
                push_item(CMD_TICK, pins, sel);
            end
            else begin
                if ($urandom_range(0, 99) < 12) begin
                    bounce_bit       = 3'($urandom_range(0, 7));
                    held[bounce_bit] = ~held[bounce_bit];
                    bounce_left      = $urandom_range(0, 4);
                end
                pins = held;
                if (bounce_left != 0) begin
                    bounce_left--;
                    if ($urandom_range(0, 1) == 1) pins[bounce_bit] = ~pins[bounce_bit];
                end
                push_item(CMD_TICK, pins, sel);
            end
        end
    endtask

    initial
    begin : main
        int unsigned r;
        int unsigned start_win;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: still inside the startup window, readings copy through.
        push_item(CMD_TICK, 8'h00, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd0);
        settle();

        // All eight buttons, short debounce, window closed.
        set_count(4'd8);
        set_reg(REG_DEBOUNCE_MS, 16'd2);
        set_reg(REG_STARTUP_MS, 16'd0);
        repeat (3) push_item(CMD_TICK, 8'h00, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd7);
        push_item(CMD_CONSUME, 8'hFF, 3'd7);
        push_item(CMD_TICK, 8'hFF, 3'd7);
        push_item(CMD_TICK, 8'hFE, 3'd0);
        repeat (3) push_item(CMD_TICK, 8'hFF, 3'd0);
        // Pins on a consume are ignored.
        push_item(CMD_CONSUME, 8'h00, 3'd4);
        settle();

        // Zero debounce accepts at once; a count above the maximum acts as eight.
        set_reg(REG_DEBOUNCE_MS, 16'd0);
        set_count(4'd15);
        push_item(CMD_TICK, 8'h55, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd3);
        push_item(CMD_TICK, 8'hAA, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd0);
        settle();

        // No buttons, then two: indexes beyond the count return nothing.
        set_count(4'd0);
        push_item(CMD_TICK, 8'h00, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd0);
        settle();
        set_count(4'd2);
        push_item(CMD_CONSUME, 8'hFF, 3'd5);
        push_item(CMD_CONSUME, 8'hFF, 3'd1);
        settle();

        // Widest window reopens startup and clears the latches.
        set_count(4'd8);
        set_reg(REG_STARTUP_MS, 16'hFFFF);
        push_item(CMD_TICK, 8'h0F, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd1);
        settle();

        // Longest debounce: nothing is accepted in a few ticks.
        set_reg(REG_STARTUP_MS, 16'd0);
        set_reg(REG_DEBOUNCE_MS, 16'hFFFF);
        set_reg(REG_UNUSED, 16'hFFFF);
        push_item(CMD_TICK, 8'hF0, 3'd0);
        push_item(CMD_TICK, 8'hF0, 3'd0);
        push_item(CMD_CONSUME, 8'hFF, 3'd6);
        settle();

        // Random phases, each with its own settings and a full drain half way.
        for (int p = 0; p < 6; p++) begin
            tx_quiet = (p == 2);
            rx_quiet <= (p == 2);
            r = $urandom_range(0, 99);
            set_count((r < 50) ? 4'd8 : 4'($urandom_range(0, 15)));
            r = $urandom_range(0, 99);
            if (r < 70)      set_reg(REG_DEBOUNCE_MS, 16'($urandom_range(0, 4)));
            else if (r < 90) set_reg(REG_DEBOUNCE_MS, 16'($urandom_range(5, 20)));
            else             set_reg(REG_DEBOUNCE_MS, 16'($urandom));
            r = $urandom_range(0, 99);
            if (r < 60) begin
                set_reg(REG_STARTUP_MS, 16'd0);
            end
            else if (r < 90) begin
                start_win = sb.uptime + $urandom_range(1, 10);
                if (start_win > 16'hFFFF) start_win = 16'hFFFF;
                set_reg(REG_STARTUP_MS, 16'(start_win));
            end
            else begin
                set_reg(REG_STARTUP_MS, 16'($urandom));
            end
            run_random(50);
            settle();
            run_random(50);
            settle();
        end

        repeat (4) @(posedge clk);
        if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), 0);
        $display("Run covered %0d ticks and %0d consumes across %0d register writes;",
                 sb.ticks, sb.consumes, sb.writes);
        $display("%0d latched presses were returned, %0d results checked.",
                 sb.presses_returned, sb.results_seen);
        if (sb.errors == 0) begin
            $display("PASS multi_button_debouncer_top");
        end
        else begin
            $display("FAIL multi_button_debouncer_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbd_pkg.sv
rtl/mbd_button_lane.sv
rtl/multi_button_debouncer_top.sv
bench/tb_top.sv
